// ===== src/adv_service_data_filter_assert.svh =====
// Assertion macros for the advertising service data filter.
// Used by the top level only; no other dependencies.
`ifndef ADV_SERVICE_DATA_FILTER_ASSERT_SVH
`define ADV_SERVICE_DATA_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SDF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define SDF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SDF_ASSERT_IMP(name, clk, rst, ante, cons)
`define SDF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== src/adv_sdf_pkg.sv =====
// Shared types and constants for the advertising service data filter.
// No dependencies; used by every module of the block.
package adv_sdf_pkg;

   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CAP_BYTES   = 8;

   localparam logic [15:0] UUID_RESET      = 16'hFFF6;
   localparam logic [7:0]  TYPE_SVC_DATA16 = 8'h16;
   localparam logic [7:0]  MIN_LEN_EXCL    = 8'd10;

   // Positions within a structure, counted after its length byte
   localparam logic [7:0] POS_TYPE      = 8'd1;
   localparam logic [7:0] POS_UUID_LO   = 8'd2;
   localparam logic [7:0] POS_UUID_HI   = 8'd3;
   localparam logic [7:0] POS_CAP_FIRST = 8'd4;
   localparam logic [7:0] POS_CAP_LAST  = 8'd11;

   typedef enum logic [0:0] {
      REG_SERVICE_UUID = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_LEN   = 2'd0,
      PH_FIELD = 2'd1,
      PH_STOP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic       take;
      logic       last;
      logic [7:0] data;
   } byte_item_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  opcode;
      logic [15:0] discriminator_version;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [7:0]  additional_flags;
   } result_type;

endpackage

// ===== src/adv_sdf_csr.sv =====
// APB-style register file of the advertising service data filter.
// Depends on adv_sdf_pkg.
module adv_sdf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adv_sdf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adv_sdf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adv_sdf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready,
   output logic [15:0]                          service_uuid
);

   logic [15:0]                 uuid_ff;
   logic [15:0]                 uuid_in;
   adv_sdf_pkg::reg_index_type  reg_index;
   logic                        wr_en;

   assign reg_index = adv_sdf_pkg::reg_index_type'(paddr[2]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      uuid_in = uuid_ff;
      prdata  = '0;
      case (reg_index)
         adv_sdf_pkg::REG_SERVICE_UUID: begin
            prdata = {{(adv_sdf_pkg::CSR_DATA_W - 16){1'b0}}, uuid_ff};
            if (wr_en) begin
               uuid_in = pwdata[15:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_ff <= adv_sdf_pkg::UUID_RESET;
      end else begin
         uuid_ff <= uuid_in;
      end
   end

   assign service_uuid = uuid_ff;

endmodule

// ===== src/adv_sdf_parser.sv =====
// Length-type-value walker and capture registers of the service data filter.
// Depends on adv_sdf_pkg.
module adv_sdf_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  adv_sdf_pkg::byte_item_type  item,
   input  logic [15:0]                 service_uuid,
   output adv_sdf_pkg::result_type     result
);

   localparam int unsigned LANE_W = $clog2(adv_sdf_pkg::CAP_BYTES);

   adv_sdf_pkg::phase_type                  phase_ff, phase_in;
   logic [7:0]                              len_ff, len_in;
   logic [7:0]                              pos_ff, pos_in;
   logic                                    match_ff, match_in;
   logic                                    found_ff, found_in;
   logic [adv_sdf_pkg::CAP_BYTES-1:0][7:0]  pend_ff, pend_in;
   logic [adv_sdf_pkg::CAP_BYTES-1:0][7:0]  commit_ff, commit_in;
   logic [adv_sdf_pkg::CAP_BYTES-1:0][7:0]  cap;
   logic [7:0]                              pos_inc;
   logic [7:0]                              cap_off;
   logic [LANE_W-1:0]                       lane;

   assign pos_inc = pos_ff + 8'd1;
   assign cap_off = pos_inc - adv_sdf_pkg::POS_CAP_FIRST;
   assign lane    = cap_off[LANE_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      found_in  = found_ff;
      pend_in   = pend_ff;
      commit_in = commit_ff;
      if (item.take) begin
         case (phase_ff)
            adv_sdf_pkg::PH_LEN: begin
               if (item.data == 8'd0) begin
                  phase_in = adv_sdf_pkg::PH_STOP;
               end else begin
                  len_in   = item.data;
                  pos_in   = 8'd0;
                  match_in = (item.data > adv_sdf_pkg::MIN_LEN_EXCL);
                  phase_in = adv_sdf_pkg::PH_FIELD;
               end
            end
            adv_sdf_pkg::PH_FIELD: begin
               pos_in = pos_inc;
               if (pos_inc == adv_sdf_pkg::POS_TYPE) begin
                  match_in = match_ff && (item.data == adv_sdf_pkg::TYPE_SVC_DATA16);
               end else if (pos_inc == adv_sdf_pkg::POS_UUID_LO) begin
                  match_in = match_ff && (item.data == service_uuid[7:0]);
               end else if (pos_inc == adv_sdf_pkg::POS_UUID_HI) begin
                  match_in = match_ff && (item.data == service_uuid[15:8]);
               end else if ((pos_inc >= adv_sdf_pkg::POS_CAP_FIRST) &&
                            (pos_inc <= adv_sdf_pkg::POS_CAP_LAST)) begin
                  pend_in[lane] = item.data;
               end
               // Structure complete: commit a match, else go on to the next one
               if (pos_inc == len_ff) begin
                  if (match_in) begin
                     commit_in = pend_in;
                     found_in  = 1'b1;
                     phase_in  = adv_sdf_pkg::PH_STOP;
                  end else begin
                     phase_in  = adv_sdf_pkg::PH_LEN;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // Result reflects this byte; clear the walk after the last byte
      cap = found_in ? commit_in : '0;
      result.found                 = found_in;
      result.opcode                = cap[0];
      result.discriminator_version = {cap[2], cap[1]};
      result.vendor_id             = {cap[4], cap[3]};
      result.product_id            = {cap[6], cap[5]};
      result.additional_flags      = cap[7];

      if (item.take && item.last) begin
         phase_in = adv_sdf_pkg::PH_LEN;
         len_in   = 8'd0;
         pos_in   = 8'd0;
         match_in = 1'b0;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= adv_sdf_pkg::PH_LEN;
         len_ff   <= 8'd0;
         pos_ff   <= 8'd0;
         match_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         match_ff <= match_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff   <= pend_in;
      commit_ff <= commit_in;
   end

endmodule

// ===== src/adv_service_data_filter.sv =====
// Flow: an accepted request is registered in the input register, then parsed from there;
//   a last-byte request passes through the parser into the result register shown on rsp_.
// Throughput: one payload byte per cycle, set by the single parse stage; only a
//   last-byte request waits, and only while an earlier result is not yet taken.
// Reset: synchronous, active high; clears the walk, the valid flags and sets
//   service_uuid to 0xFFF6. No clearing pass is needed.
module adv_service_data_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   // Byte requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_adv_byte,
   input  logic                                 req_last_byte,
   input  logic [47:0]                          req_peer_address,
   input  logic [1:0]                           req_peer_address_type,
   // Results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [7:0]                           rsp_opcode,
   output logic [15:0]                          rsp_discriminator_version,
   output logic [15:0]                          rsp_vendor_id,
   output logic [15:0]                          rsp_product_id,
   output logic [7:0]                           rsp_additional_flags,
   output logic [47:0]                          rsp_reported_address,
   output logic [1:0]                           rsp_reported_address_type,
   // Configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adv_sdf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adv_sdf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adv_sdf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready
);

`include "adv_service_data_filter_assert.svh"

   // Input register: holds one accepted request until the parser takes it
   logic                        stage_valid_ff, stage_valid_in;
   logic [7:0]                  stage_byte_ff;
   logic                        stage_last_ff;
   logic [47:0]                 stage_addr_ff;
   logic [1:0]                  stage_atype_ff;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   adv_sdf_pkg::result_type     rsp_result_ff;
   logic [47:0]                 rsp_addr_ff;
   logic [1:0]                  rsp_atype_ff;

   logic                        req_take;
   logic                        stage_take;
   logic                        out_free;
   logic                        capture_zero;
   logic [15:0]                 service_uuid;
   adv_sdf_pkg::byte_item_type  item;
   adv_sdf_pkg::result_type     result;

   adv_sdf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .service_uuid (service_uuid)
   );

   // Non-last bytes never touch the result register, so they advance freely;
   // a last byte advances only when the result slot is empty or draining.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_take = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_ready  = !stage_valid_ff || stage_take;
   assign req_take   = req_valid && req_ready;

   assign item.take = stage_take;
   assign item.last = stage_last_ff;
   assign item.data = stage_byte_ff;

   adv_sdf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .service_uuid (service_uuid),
      .result       (result)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (stage_take) begin
         stage_valid_in = 1'b0;
      end
      if (req_take) begin
         stage_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stage_take && stage_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Load the input register on accept; hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff  <= req_adv_byte;
         stage_last_ff  <= req_last_byte;
         stage_addr_ff  <= req_peer_address;
         stage_atype_ff <= req_peer_address_type;
      end
   end

   // Load the result register when a last byte leaves the parser
   always_ff @(posedge clock) begin
      if (stage_take && stage_last_ff) begin
         rsp_result_ff <= result;
         rsp_addr_ff   <= stage_addr_ff;
         rsp_atype_ff  <= stage_atype_ff;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_found                 = rsp_result_ff.found;
   assign rsp_opcode                = rsp_result_ff.opcode;
   assign rsp_discriminator_version = rsp_result_ff.discriminator_version;
   assign rsp_vendor_id             = rsp_result_ff.vendor_id;
   assign rsp_product_id            = rsp_result_ff.product_id;
   assign rsp_additional_flags      = rsp_result_ff.additional_flags;
   assign rsp_reported_address      = rsp_addr_ff;
   assign rsp_reported_address_type = rsp_atype_ff;

   // Opcode, vendor ID, product ID and flags of the held result are all zero
   assign capture_zero = (rsp_result_ff.opcode == 8'd0) &&
                         (rsp_result_ff.vendor_id == 16'd0) &&
                         (rsp_result_ff.product_id == 16'd0) &&
                         (rsp_result_ff.additional_flags == 8'd0);

   // A last byte that leaves the parser must show up as a result
   `SDF_ASSERT_NXT(a_last_gives_result, clock, reset, stage_take && stage_last_ff, rsp_valid_ff)
   // Ready with a full input register only when that register drains now
   `SDF_ASSERT_IMP(a_ready_drains_stage, clock, reset, req_ready && stage_valid_ff, stage_take)
   // A result without a match carries zero opcode, vendor ID, product ID and flags
   `SDF_ASSERT_IMP(a_no_match_zero, clock, reset, rsp_valid_ff && !rsp_result_ff.found, capture_zero)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for adv_service_data_filter: byte requests, results, CSR port.
// Predicts found flag, capture fields and address per payload; uses adv_sdf_pkg only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One byte request as the driver offers it
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [47:0] addr;
      logic [1:0]  atype;
   } byte_request_type;

   // One expected result: the capture fields plus the advertiser address
   typedef struct packed {
      adv_sdf_pkg::result_type body;
      logic [47:0]             addr;
      logic [1:0]              atype;
   } adv_report_type;

   localparam int LONG_HOLD_CYCLES = 150;
   localparam int PHASE_REQUESTS   = 230;
   localparam int NUM_PHASES       = 6;
   localparam int CSR_AW           = adv_sdf_pkg::CSR_ADDR_W;
   localparam int CSR_DW           = adv_sdf_pkg::CSR_DATA_W;

   // Clock and reset; every block input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_adv_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic [47:0]           req_peer_address = '0;
   logic [1:0]            req_peer_address_type = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [7:0]            rsp_opcode;
   logic [15:0]           rsp_discriminator_version;
   logic [15:0]           rsp_vendor_id;
   logic [15:0]           rsp_product_id;
   logic [7:0]            rsp_additional_flags;
   logic [47:0]           rsp_reported_address;
   logic [1:0]            rsp_reported_address_type;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_AW-1:0]     paddr = '0;
   logic [CSR_DW-1:0]     pwdata = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   adv_service_data_filter dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_adv_byte              (req_adv_byte),
      .req_last_byte             (req_last_byte),
      .req_peer_address          (req_peer_address),
      .req_peer_address_type     (req_peer_address_type),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_found                 (rsp_found),
      .rsp_opcode                (rsp_opcode),
      .rsp_discriminator_version (rsp_discriminator_version),
      .rsp_vendor_id             (rsp_vendor_id),
      .rsp_product_id            (rsp_product_id),
      .rsp_additional_flags      (rsp_additional_flags),
      .rsp_reported_address      (rsp_reported_address),
      .rsp_reported_address_type (rsp_reported_address_type),
      .psel                      (psel),
      .penable                   (penable),
      .pwrite                    (pwrite),
      .paddr                     (paddr),
      .pwdata                    (pwdata),
      .prdata                    (prdata),
      .pready                    (pready)
   );

   always #5 clock = ~clock;

   // Bookkeeping shared between the stimulus, the driver and the monitor
   byte_request_type byte_requests[$];    // requests not yet offered
   adv_report_type   pending_reports[$];  // results predicted but not yet seen
   logic [7:0]       frame[$];            // payload under construction
   int               requests_queued = 0;
   int               requests_accepted = 0;
   int               failures = 0;
   bit               req_taken = 1'b0;    // request accepted at the last rising edge
   logic [15:0]      uuid_setting = adv_sdf_pkg::UUID_RESET;  // UUID the stimulus aims at

   // Long receiver hold-off: the stimulus asks, the ready process serves
   int            stall_requests = 0;
   int            stall_served = 0;

   // Predictor copy of the filter: configuration and walk state
   logic [15:0]            uuid_cfg;
   adv_sdf_pkg::phase_type walk_phase;
   logic [7:0]             struct_len;
   logic [7:0]             struct_pos;
   bit                     struct_hit;
   logic [63:0]            staged_bytes;
   logic [63:0]            kept_bytes;
   bit                     hit_seen;

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [47:0] got,
                              input logic [47:0] want);
      if (got !== want)
         log_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
   endtask

   // Gap length: mostly none, some short, a few long, with quiet stretches of none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   task automatic clear_walk();
      walk_phase   = adv_sdf_pkg::PH_LEN;
      struct_len   = '0;
      struct_pos   = '0;
      struct_hit   = 1'b0;
      staged_bytes = '0;
      kept_bytes   = '0;
      hit_seen     = 1'b0;
   endtask

   // Advance the walk by one payload byte; on the last byte queue the expected result
   task automatic walk_adv_byte(input byte_request_type r);
      adv_report_type rep;
      logic [63:0]    shown;
      int             slot;
      if (walk_phase == adv_sdf_pkg::PH_LEN) begin
         if (r.data == 8'h00) begin
            walk_phase = adv_sdf_pkg::PH_STOP;
         end else begin
            struct_len   = r.data;
            struct_pos   = '0;
            struct_hit   = (r.data > adv_sdf_pkg::MIN_LEN_EXCL);
            staged_bytes = '0;
            walk_phase   = adv_sdf_pkg::PH_FIELD;
         end
      end else if (walk_phase == adv_sdf_pkg::PH_FIELD) begin
         struct_pos = struct_pos + 8'd1;
         if (struct_pos == adv_sdf_pkg::POS_TYPE) begin
            struct_hit = struct_hit && (r.data == adv_sdf_pkg::TYPE_SVC_DATA16);
         end else if (struct_pos == adv_sdf_pkg::POS_UUID_LO) begin
            struct_hit = struct_hit && (r.data == uuid_cfg[7:0]);
         end else if (struct_pos == adv_sdf_pkg::POS_UUID_HI) begin
            struct_hit = struct_hit && (r.data == uuid_cfg[15:8]);
         end else if (struct_pos >= adv_sdf_pkg::POS_CAP_FIRST &&
                      struct_pos <= adv_sdf_pkg::POS_CAP_LAST) begin
            slot = int'(struct_pos - adv_sdf_pkg::POS_CAP_FIRST);
            staged_bytes[8*slot +: 8] |= r.data;
         end
         // Close the structure: commit a match and stop, else expect the next length
         if (struct_pos == struct_len) begin
            if (struct_hit) begin
               kept_bytes = staged_bytes;
               hit_seen   = 1'b1;
               walk_phase = adv_sdf_pkg::PH_STOP;
            end else begin
               walk_phase = adv_sdf_pkg::PH_LEN;
            end
         end
      end
      if (r.last) begin
         shown                          = hit_seen ? kept_bytes : '0;
         rep.body.found                 = hit_seen;
         rep.body.opcode                = shown[7:0];
         rep.body.discriminator_version = shown[23:8];
         rep.body.vendor_id             = shown[39:24];
         rep.body.product_id            = shown[55:40];
         rep.body.additional_flags      = shown[63:56];
         rep.addr                       = r.addr;
         rep.atype                      = r.atype;
         pending_reports.push_back(rep);
         clear_walk();
      end
   endtask

   // Monitor: sample both channels and the CSR port at the rising edge
   always @(posedge clock) begin
      adv_report_type   want;
      byte_request_type seen;
      if (reset) begin
         uuid_cfg  = adv_sdf_pkg::UUID_RESET;
         req_taken = 1'b0;
         clear_walk();
      end else begin
         req_taken = req_valid && req_ready;
         // Check the result against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               log_failure($sformatf("result with no request behind it (found %0b addr 0x%0h)",
                                     rsp_found, rsp_reported_address));
            end else begin
               want = pending_reports.pop_front();
               check_field("found", rsp_found, want.body.found);
               check_field("opcode", rsp_opcode, want.body.opcode);
               check_field("discriminator_version", rsp_discriminator_version,
                           want.body.discriminator_version);
               check_field("vendor_id", rsp_vendor_id, want.body.vendor_id);
               check_field("product_id", rsp_product_id, want.body.product_id);
               check_field("additional_flags", rsp_additional_flags,
                           want.body.additional_flags);
               check_field("reported_address", rsp_reported_address, want.addr);
               check_field("reported_address_type", rsp_reported_address_type, want.atype);
            end
         end
         // Predict from the accepted request
         if (req_taken) begin
            seen.data  = req_adv_byte;
            seen.last  = req_last_byte;
            seen.addr  = req_peer_address;
            seen.atype = req_peer_address_type;
            walk_adv_byte(seen);
            requests_accepted++;
         end
         // Track register writes
         if (psel && penable && pwrite && pready &&
             paddr == CSR_AW'(4 * int'(adv_sdf_pkg::REG_SERVICE_UUID)))
            uuid_cfg = pwdata[15:0];
      end
   end

   // Driver: hold the request until accepted, then idle or advance to the next one
   int send_gap = 0;
   int send_calm = 0;
   always @(negedge clock) begin
      byte_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold: the offered request has not been taken yet
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (byte_requests.size() != 0) begin
         nxt = byte_requests.pop_front();
         req_adv_byte          <= nxt.data;
         req_last_byte         <= nxt.last;
         req_peer_address      <= nxt.addr;
         req_peer_address_type <= nxt.atype;
         req_valid             <= 1'b1;
         send_gap = pick_gap(send_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random back-pressure, plus a long hold-off when the stimulus asks
   int hold_left = 0;
   int ready_gap = 0;
   int ready_calm = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         ready_gap = pick_gap(ready_calm);
      end
   end

   // One APB transfer: setup cycle, access cycle, then release the bus
   task automatic csr_cycle(input bit is_write, input adv_sdf_pkg::reg_index_type idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_AW'(4 * int'(idx));
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Queue the payload under construction, last-byte mark on its final byte
   task automatic send_frame();
      byte_request_type r;
      logic [47:0]      who;
      logic [1:0]       who_type;
      if (frame.size() == 0)
         frame.push_back(8'($urandom));
      who      = 48'({$urandom, $urandom});
      who_type = 2'($urandom);
      foreach (frame[i]) begin
         r.data  = frame[i];
         r.last  = (i == frame.size() - 1);
         r.addr  = who;
         r.atype = who_type;
         byte_requests.push_back(r);
      end
      requests_queued += frame.size();
      frame.delete();
   endtask

   // Append one length-type-value structure; a zero length appends the stop byte only
   task automatic add_struct(input int len, input logic [7:0] kind, input logic [15:0] uuid);
      frame.push_back(8'(len));
      for (int p = 1; p <= len; p++) begin
         if (p == 1) frame.push_back(kind);
         else if (p == 2) frame.push_back(uuid[7:0]);
         else if (p == 3) frame.push_back(uuid[15:8]);
         else frame.push_back(8'($urandom));
      end
   endtask

   // Length of a candidate structure: mostly short, now and then the longest
   function automatic int wanted_len();
      if ($urandom_range(0, 49) == 0) return 255;
      return $urandom_range(11, 20);
   endfunction

   // Build a payload: a few lead structures, one candidate of some flavor, a tail
   task automatic build_random_frame();
      int          pick;
      int          cut;
      logic [15:0] off_uuid;
      pick     = $urandom_range(0, 99);
      cut      = 0;
      off_uuid = uuid_setting ^ (16'h1 << $urandom_range(0, 15));
      repeat ($urandom_range(0, 2))
         add_struct($urandom_range(1, 8), 8'($urandom), 16'($urandom));
      if (pick < 50) begin
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, uuid_setting);
      end else if (pick < 58) begin
         add_struct(wanted_len(), 8'($urandom), uuid_setting);
      end else if (pick < 66) begin
         // one UUID bit off
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, off_uuid);
      end else if (pick < 71) begin
         // length one short of qualifying
         add_struct(int'(adv_sdf_pkg::MIN_LEN_EXCL), adv_sdf_pkg::TYPE_SVC_DATA16,
                    uuid_setting);
      end else if (pick < 76) begin
         // zero length stops the walk before a good structure
         frame.push_back(8'h00);
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, uuid_setting);
      end else if (pick < 82) begin
         // two good structures: only the first is captured
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, uuid_setting);
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, uuid_setting);
      end else if (pick < 92) begin
         // good structure cut off by the payload end
         add_struct(wanted_len(), adv_sdf_pkg::TYPE_SVC_DATA16, uuid_setting);
         cut = $urandom_range(1, 11);
      end else begin
         repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
      end
      if (cut > 0) begin
         repeat (cut) void'(frame.pop_back());
      end else begin
         repeat ($urandom_range(0, 2))
            add_struct($urandom_range(0, 6), 8'($urandom), 16'($urandom));
      end
      send_frame();
   endtask

   // Pause until every queued request is taken and every result has come back
   task automatic wait_idle();
      while (requests_accepted != requests_queued || pending_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Main sequence: reset, then one phase per UUID setting
   initial begin
      logic [15:0] uuid_plan[NUM_PHASES];
      logic [31:0] readback;
      int          target;
      uuid_plan = '{adv_sdf_pkg::UUID_RESET, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                    adv_sdf_pkg::UUID_RESET};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // Reprogram while idle and read the register back; phase 0 runs on the reset value
         if (ph == 3 || ph == 4)
            uuid_plan[ph] = 16'($urandom);
         if (ph != 0) begin
            csr_cycle(1'b1, adv_sdf_pkg::REG_SERVICE_UUID, {16'h0, uuid_plan[ph]}, readback);
            csr_cycle(1'b0, adv_sdf_pkg::REG_SERVICE_UUID, '0, readback);
            if (readback !== {16'h0, uuid_plan[ph]})
               log_failure($sformatf("service_uuid read 0x%0h, wrote 0x%0h",
                                     readback, uuid_plan[ph]));
         end
         uuid_setting = uuid_plan[ph];

         if (ph == 0) begin
            // Shortest match, capture bytes at the extremes
            frame = '{8'h0B, adv_sdf_pkg::TYPE_SVC_DATA16, adv_sdf_pkg::UUID_RESET[7:0],
                      adv_sdf_pkg::UUID_RESET[15:8],
                      8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
            send_frame();
            // Lone zero length: stop at once, nothing found
            frame.push_back(8'h00);
            send_frame();
            // Lone maximal length: cut off by the payload end
            frame.push_back(8'hFF);
            send_frame();
            // Right type and UUID but length not over the minimum
            add_struct(int'(adv_sdf_pkg::MIN_LEN_EXCL), adv_sdf_pkg::TYPE_SVC_DATA16,
                       adv_sdf_pkg::UUID_RESET);
            send_frame();
         end

         if (ph == 3) begin
            // Hold the receiver off and keep offering one-byte payloads to back up the input
            stall_requests++;
            repeat (40) begin
               frame.push_back(8'($urandom));
               send_frame();
            end
         end

         target = requests_queued + PHASE_REQUESTS;
         while (requests_queued < target)
            build_random_frame();
         wait_idle();
      end

      repeat (8) @(negedge clock);
      if (failures == 0 && pending_reports.size() == 0)
         $display("** adv_service_data_filter: PASSED **");
      else
         $display("** adv_service_data_filter: FAILED **");
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here
   initial begin
      #5_000_000;
      $display("** adv_service_data_filter: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/adv_sdf_pkg.sv
src/adv_sdf_csr.sv
src/adv_sdf_parser.sv
src/adv_service_data_filter.sv
tb/tb_top.sv
